@@ rtl/cfpr_pkg.sv @@
// Shared types and constants of the command frame parser and responder.
`default_nettype none
package cfpr_pkg;

  localparam int unsigned MaxPayload = 32;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned QCntW      = $clog2(QDepth + 1);

  localparam logic [7:0] HdrByte    = 8'hAA;
  localparam logic [7:0] RspAck     = 8'hFE;
  localparam logic [7:0] RspNack    = 8'hFF;
  localparam logic [7:0] RspStatus  = 8'h10;
  localparam logic [7:0] Bright     = 8'd50;
  localparam logic [7:0] LenAck     = 8'h00;
  localparam logic [7:0] LenNack    = 8'h01;
  localparam logic [7:0] LenStatus  = 8'h02;

  localparam logic [7:0] CmdLed0On  = 8'h01;
  localparam logic [7:0] CmdLed0Off = 8'h02;
  localparam logic [7:0] CmdLed1On  = 8'h03;
  localparam logic [7:0] CmdLed1Off = 8'h04;
  localparam logic [7:0] CmdCheck   = 8'h05;

  localparam logic [3:0] AckLastIdx  = 4'd4;
  localparam logic [3:0] NackLastIdx = 4'd5;
  localparam logic [3:0] BothLastIdx = 4'd11;
  localparam logic [3:0] AckBytes    = 4'd5;

  typedef enum logic [1:0] {
    ERR_SUM    = 2'd1,
    ERR_LENGTH = 2'd2,
    ERR_CMD    = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    RSP_ACK        = 2'd0,
    RSP_NACK       = 2'd1,
    RSP_ACK_STATUS = 2'd2
  } rsp_kind_e;

  typedef enum logic [5:0] {
    PH_HDR = 6'b000001,
    PH_CMD = 6'b000010,
    PH_SEQ = 6'b000100,
    PH_LEN = 6'b001000,
    PH_PAY = 6'b010000,
    PH_SUM = 6'b100000
  } phase_e;

  typedef struct packed {
    rsp_kind_e  kind;
    err_e       err;
    logic [7:0] seq;
    logic       led0;
    logic       led1;
  } rsp_t;

endpackage
`default_nettype wire

@@ rtl/cfpr_intf.sv @@
// Valid/ready channel interfaces for received and transmitted bytes.
`default_nettype none
interface cfpr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfpr_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic       led0_on;
  logic       led1_on;
  modport source (output valid, output tx_byte, output tx_last, output led0_on,
                  output led1_on, input ready);
  modport sink (input valid, input tx_byte, input tx_last, input led0_on,
                input led1_on, output ready);
endinterface
`default_nettype wire

@@ rtl/command_frame_parser_responder.sv @@
// Top level of the command frame parser and responder.
//
// Channels: rx takes one received byte per beat; tx gives one response byte
// per beat with tx_last on the final byte caused by one received byte, and
// the LED states as they stand after that byte.
// Frames are AA, command, sequence, length, payload, additive checksum.
// Responses are ACK (5 bytes), NACK (6 bytes) or ACK plus STATUS (12 bytes).
// The parser takes one byte every cycle while the response queue has room;
// the first response byte reaches tx through the queue write and then the
// output register. The serializer sends one byte per cycle while tx is
// ready, so sustained response output is then one beat per cycle.
// When tx stalls, the output register holds its beat, the serializer holds
// its position, and the 4-entry queue fills; rx ready drops only while the
// queue is full, and then every byte waits, also one that causes no response.
// Reset returns the parser to header search, turns both LEDs off and empties
// the queue and output register.
`default_nettype none
module command_frame_parser_responder (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cfpr_rx_if.sink    rx,
  cfpr_tx_if.source  tx
);

  logic           f_valid, f_ready;
  cfpr_pkg::rsp_t f_rsp;
  logic           b_valid, b_ready;
  cfpr_pkg::rsp_t b_rsp;

  cfpr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx.valid),
    .rx_ready_o  (rx.ready),
    .rx_byte_i   (rx.rx_byte),
    .rsp_valid_o (f_valid),
    .rsp_ready_i (f_ready),
    .rsp_o       (f_rsp)
  );

  cfpr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_rsp),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_rsp)
  );

  cfpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rsp_valid_i (b_valid),
    .rsp_ready_o (b_ready),
    .rsp_i       (b_rsp),
    .tx          (tx)
  );

endmodule
`default_nettype wire

@@ rtl/cfpr_front.sv @@
// Frame parser: checks header, length and checksum and issues responses.
`default_nettype none
module cfpr_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rx_valid_i,
  output logic               rx_ready_o,
  input  wire logic [7:0]    rx_byte_i,
  output logic               rsp_valid_o,
  input  wire logic          rsp_ready_i,
  output cfpr_pkg::rsp_t     rsp_o
);

  cfpr_pkg::phase_e phase_q, phase_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] seq_q, seq_d;
  logic [5:0] len_q, len_d;
  logic [5:0] cnt_q, cnt_d;
  logic [7:0] sum_q, sum_d;
  logic       led0_q, led0_d;
  logic       led1_q, led1_d;
  logic       accept;
  logic       gen;
  logic [5:0] cnt_inc;

  assign rx_ready_o  = rsp_ready_i;
  assign accept      = rx_valid_i && rsp_ready_i;
  assign rsp_valid_o = accept && gen;
  assign cnt_inc     = cnt_q + 6'd1;

  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    seq_d     = seq_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    led0_d    = led0_q;
    led1_d    = led1_q;
    gen       = 1'b0;
    rsp_o.kind = cfpr_pkg::RSP_NACK;
    rsp_o.err  = cfpr_pkg::ERR_CMD;
    rsp_o.seq  = seq_q;
    unique case (phase_q)
      cfpr_pkg::PH_HDR: begin
        if (rx_byte_i == cfpr_pkg::HdrByte) begin
          phase_d = cfpr_pkg::PH_CMD;
          cnt_d   = '0;
        end
      end
      cfpr_pkg::PH_CMD: begin
        cmd_d   = rx_byte_i;
        sum_d   = rx_byte_i;
        cnt_d   = '0;
        phase_d = cfpr_pkg::PH_SEQ;
      end
      cfpr_pkg::PH_SEQ: begin
        seq_d   = rx_byte_i;
        sum_d   = sum_q + rx_byte_i;
        phase_d = cfpr_pkg::PH_LEN;
      end
      cfpr_pkg::PH_LEN: begin
        if (rx_byte_i > 8'(cfpr_pkg::MaxPayload)) begin
          gen       = 1'b1;
          rsp_o.err = cfpr_pkg::ERR_LENGTH;
          phase_d   = cfpr_pkg::PH_HDR;
        end else begin
          len_d   = rx_byte_i[5:0];
          cnt_d   = '0;
          sum_d   = sum_q + rx_byte_i;
          phase_d = (rx_byte_i == 8'd0) ? cfpr_pkg::PH_SUM : cfpr_pkg::PH_PAY;
        end
      end
      cfpr_pkg::PH_PAY: begin
        sum_d = sum_q + rx_byte_i;
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q) begin
          phase_d = cfpr_pkg::PH_SUM;
        end
      end
      cfpr_pkg::PH_SUM: begin
        gen     = 1'b1;
        phase_d = cfpr_pkg::PH_HDR;
        if (sum_q != rx_byte_i) begin
          rsp_o.err = cfpr_pkg::ERR_SUM;
        end else begin
          unique case (cmd_q)
            cfpr_pkg::CmdLed0On: begin
              led0_d     = 1'b1;
              rsp_o.kind = cfpr_pkg::RSP_ACK_STATUS;
            end
            cfpr_pkg::CmdLed0Off: begin
              led0_d     = 1'b0;
              rsp_o.kind = cfpr_pkg::RSP_ACK;
            end
            cfpr_pkg::CmdLed1On: begin
              led1_d     = 1'b1;
              rsp_o.kind = cfpr_pkg::RSP_ACK;
            end
            cfpr_pkg::CmdLed1Off: begin
              led1_d     = 1'b0;
              rsp_o.kind = cfpr_pkg::RSP_ACK;
            end
            cfpr_pkg::CmdCheck: begin
              if (len_q != 6'd0) begin
                rsp_o.kind = cfpr_pkg::RSP_ACK;
              end else begin
                rsp_o.err = cfpr_pkg::ERR_LENGTH;
              end
            end
            default: begin
              rsp_o.err = cfpr_pkg::ERR_CMD;
            end
          endcase
        end
      end
      default: begin
        phase_d = cfpr_pkg::PH_HDR;
      end
    endcase
    rsp_o.led0 = led0_d;
    rsp_o.led1 = led1_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cfpr_pkg::PH_HDR;
      cmd_q   <= '0;
      seq_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      led0_q  <= 1'b0;
      led1_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      seq_q   <= seq_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      led0_q  <= led0_d;
      led1_q  <= led1_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/cfpr_queue.sv @@
// Short response queue between parser and frame serializer.
`default_nettype none
module cfpr_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire cfpr_pkg::rsp_t push_data_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output cfpr_pkg::rsp_t      pop_data_o
);

  cfpr_pkg::rsp_t                 mem_q [cfpr_pkg::QDepth];
  logic [cfpr_pkg::QPtrW-1:0]     wr_q, rd_q;
  logic [cfpr_pkg::QCntW-1:0]     cnt_q;
  logic                           push, pop;

  assign push_ready_o = cnt_q != cfpr_pkg::QCntW'(cfpr_pkg::QDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      priority if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/cfpr_back.sv @@
// Frame serializer: turns queued responses into transmit beats.
`default_nettype none
module cfpr_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           rsp_valid_i,
  output logic                rsp_ready_o,
  input  wire cfpr_pkg::rsp_t rsp_i,
  cfpr_tx_if.source           tx
);

  logic [3:0] idx_q;
  logic [3:0] last_idx;
  logic [3:0] pos;
  logic       in_status;
  logic       is_last;
  logic       advance;
  logic       load;
  logic [7:0] byte_val;
  logic [7:0] err_byte;
  logic [7:0] led_byte;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q, led0_q, led1_q;

  assign err_byte = {6'd0, rsp_i.err};
  assign led_byte = {6'd0, rsp_i.led1, rsp_i.led0};
  assign advance  = !valid_q || tx.ready;
  assign load     = advance && rsp_valid_i;
  assign is_last  = idx_q == last_idx;
  assign rsp_ready_o = load && is_last;

  always_comb begin
    unique case (rsp_i.kind)
      cfpr_pkg::RSP_ACK:        last_idx = cfpr_pkg::AckLastIdx;
      cfpr_pkg::RSP_NACK:       last_idx = cfpr_pkg::NackLastIdx;
      cfpr_pkg::RSP_ACK_STATUS: last_idx = cfpr_pkg::BothLastIdx;
      default:                  last_idx = cfpr_pkg::AckLastIdx;
    endcase
    in_status = (rsp_i.kind == cfpr_pkg::RSP_ACK_STATUS) && (idx_q >= cfpr_pkg::AckBytes);
    pos       = in_status ? idx_q - cfpr_pkg::AckBytes : idx_q;
    byte_val  = cfpr_pkg::HdrByte;
    if (in_status) begin
      unique case (pos)
        4'd0:    byte_val = cfpr_pkg::HdrByte;
        4'd1:    byte_val = cfpr_pkg::RspStatus;
        4'd2:    byte_val = rsp_i.seq;
        4'd3:    byte_val = cfpr_pkg::LenStatus;
        4'd4:    byte_val = led_byte;
        4'd5:    byte_val = cfpr_pkg::Bright;
        default: byte_val = cfpr_pkg::RspStatus + rsp_i.seq + cfpr_pkg::LenStatus
                            + led_byte + cfpr_pkg::Bright;
      endcase
    end else if (rsp_i.kind == cfpr_pkg::RSP_NACK) begin
      unique case (pos)
        4'd0:    byte_val = cfpr_pkg::HdrByte;
        4'd1:    byte_val = cfpr_pkg::RspNack;
        4'd2:    byte_val = rsp_i.seq;
        4'd3:    byte_val = cfpr_pkg::LenNack;
        4'd4:    byte_val = err_byte;
        default: byte_val = cfpr_pkg::RspNack + rsp_i.seq + cfpr_pkg::LenNack + err_byte;
      endcase
    end else begin
      unique case (pos)
        4'd0:    byte_val = cfpr_pkg::HdrByte;
        4'd1:    byte_val = cfpr_pkg::RspAck;
        4'd2:    byte_val = rsp_i.seq;
        4'd3:    byte_val = cfpr_pkg::LenAck;
        default: byte_val = cfpr_pkg::RspAck + rsp_i.seq + cfpr_pkg::LenAck;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (advance) begin
      valid_q <= rsp_valid_i;
      if (load) begin
        idx_q <= is_last ? 4'd0 : idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_val;
      last_q <= is_last;
      led0_q <= rsp_i.led0;
      led1_q <= rsp_i.led1;
    end
  end

  assign tx.valid   = valid_q;
  assign tx.tx_byte = byte_q;
  assign tx.tx_last = last_q;
  assign tx.led0_on = led0_q;
  assign tx.led1_on = led1_q;

endmodule
`default_nettype wire

@@ tb/frame_response_checker.sv @@
// Checker that predicts response beats from accepted rx beats and compares tx beats.
`timescale 1ns / 100ps
module frame_response_checker import cfpr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  cfpr_rx_if   rx,
  cfpr_tx_if   tx,
  output int   errors_o,
  output int   pending_o
);

  localparam int PrintCap = 50;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       led0;
    logic       led1;
  } tx_beat_t;

  phase_e     parse_ph;
  logic [7:0] frame_cmd;
  logic [7:0] frame_seq;
  logic [5:0] frame_len;
  logic [5:0] pay_count;
  logic [7:0] run_sum;
  logic       led0_lit;
  logic       led1_lit;

  logic [7:0] rsp_bytes[$];
  tx_beat_t   expected_tx_q[$];
  tx_beat_t   want_beat;
  int         errors;
  int         pending;

  assign errors_o  = errors;
  assign pending_o = pending;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (errors < PrintCap) begin
      $display("%0t ns: tx %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
    end
    errors++;
  endtask

  task automatic put_frame(input logic [7:0] kind, input logic [7:0] seq,
                           input logic [7:0] len, input logic [7:0] p0,
                           input logic [7:0] p1);
    logic [7:0] sum;
    sum = kind + seq + len;
    rsp_bytes.push_back(HdrByte);
    rsp_bytes.push_back(kind);
    rsp_bytes.push_back(seq);
    rsp_bytes.push_back(len);
    if (len > 0) begin
      rsp_bytes.push_back(p0);
      sum += p0;
    end
    if (len > 1) begin
      rsp_bytes.push_back(p1);
      sum += p1;
    end
    rsp_bytes.push_back(sum);
  endtask

  task automatic predict_rx(input logic [7:0] b);
    tx_beat_t beat;
    rsp_bytes.delete();
    case (parse_ph)
      PH_HDR: begin
        if (b == HdrByte) begin
          parse_ph  = PH_CMD;
          pay_count = '0;
        end
      end
      PH_CMD: begin
        frame_cmd = b;
        run_sum   = b;
        pay_count = '0;
        parse_ph  = PH_SEQ;
      end
      PH_SEQ: begin
        frame_seq = b;
        run_sum  += b;
        parse_ph  = PH_LEN;
      end
      PH_LEN: begin
        if (b > MaxPayload) begin
          put_frame(RspNack, frame_seq, LenNack, 8'(ERR_LENGTH), 8'h00);
          parse_ph = PH_HDR;
        end else begin
          frame_len = b[5:0];
          pay_count = '0;
          run_sum  += b;
          parse_ph  = (b == 8'h00) ? PH_SUM : PH_PAY;
        end
      end
      PH_PAY: begin
        run_sum  += b;
        pay_count = pay_count + 6'd1;
        if (pay_count >= frame_len) parse_ph = PH_SUM;
      end
      PH_SUM: begin
        if (run_sum == b) begin
          case (frame_cmd)
            CmdLed0On: begin
              led0_lit = 1'b1;
              put_frame(RspAck, frame_seq, LenAck, 8'h00, 8'h00);
              put_frame(RspStatus, frame_seq, LenStatus, {6'd0, led1_lit, led0_lit}, Bright);
            end
            CmdLed0Off: begin
              led0_lit = 1'b0;
              put_frame(RspAck, frame_seq, LenAck, 8'h00, 8'h00);
            end
            CmdLed1On: begin
              led1_lit = 1'b1;
              put_frame(RspAck, frame_seq, LenAck, 8'h00, 8'h00);
            end
            CmdLed1Off: begin
              led1_lit = 1'b0;
              put_frame(RspAck, frame_seq, LenAck, 8'h00, 8'h00);
            end
            CmdCheck: begin
              if (frame_len != '0) put_frame(RspAck, frame_seq, LenAck, 8'h00, 8'h00);
              else put_frame(RspNack, frame_seq, LenNack, 8'(ERR_LENGTH), 8'h00);
            end
            default: put_frame(RspNack, frame_seq, LenNack, 8'(ERR_CMD), 8'h00);
          endcase
        end else begin
          put_frame(RspNack, frame_seq, LenNack, 8'(ERR_SUM), 8'h00);
        end
        parse_ph = PH_HDR;
      end
      default: parse_ph = PH_HDR;
    endcase
    foreach (rsp_bytes[i]) begin
      beat.data = rsp_bytes[i];
      beat.last = (i == rsp_bytes.size() - 1);
      beat.led0 = led0_lit;
      beat.led1 = led1_lit;
      expected_tx_q.push_back(beat);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_ph  = PH_HDR;
      frame_cmd = '0;
      frame_seq = '0;
      frame_len = '0;
      pay_count = '0;
      run_sum   = '0;
      led0_lit  = 1'b0;
      led1_lit  = 1'b0;
      errors    = 0;
      pending   = 0;
      expected_tx_q.delete();
    end else begin
      if (rx.valid && rx.ready) predict_rx(rx.rx_byte);
      if (tx.valid && tx.ready) begin
        if (expected_tx_q.size() == 0) begin
          report_mismatch("beat with nothing expected", tx.tx_byte, 8'h00);
        end else begin
          want_beat = expected_tx_q.pop_front();
          if (tx.tx_byte !== want_beat.data) report_mismatch("tx_byte", tx.tx_byte, want_beat.data);
          if (tx.tx_last !== want_beat.last) report_mismatch("tx_last", 8'(tx.tx_last), 8'(want_beat.last));
          if (tx.led0_on !== want_beat.led0) report_mismatch("led0_on", 8'(tx.led0_on), 8'(want_beat.led0));
          if (tx.led1_on !== want_beat.led1) report_mismatch("led1_on", 8'(tx.led1_on), 8'(want_beat.led1));
        end
      end
      pending = expected_tx_q.size();
    end
  end

endmodule

@@ tb/tb_command_frame_parser_responder.sv @@
// Testbench top: clock, reset, frame stimulus, tx back-pressure and verdict.
`timescale 1ns / 100ps
module tb_command_frame_parser_responder;
  import cfpr_pkg::*;

  localparam int         StallLimit     = 2000;
  localparam int         TxHoldCycles   = 100;
  localparam int         PhaseBytes     = 85;
  localparam int         TailCycles     = 8;
  localparam logic [7:0] UnknownCmdLow  = 8'h00;
  localparam logic [7:0] UnknownCmdHigh = 8'hFF;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   pending;
  int   rx_idle_pct;
  int   tx_idle_pct;
  int   holds_asked;
  int   bytes_sent;

  cfpr_rx_if rx_ch ();
  cfpr_tx_if tx_ch ();

  command_frame_parser_responder DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx    (rx_ch),
    .tx    (tx_ch)
  );

  frame_response_checker u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx       (rx_ch),
    .tx       (tx_ch),
    .errors_o (errors),
    .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < rx_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_ch.ready) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] seq,
                            input logic [7:0] len, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] pb;
    send_byte(HdrByte);
    send_byte(cmd);
    send_byte(seq);
    send_byte(len);
    if (len > MaxPayload) return;
    sum = cmd + seq + len;
    repeat (len) begin
      pb   = 8'($urandom);
      sum += pb;
      send_byte(pb);
    end
    if (bad_sum) sum ^= 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  task automatic send_random_frame();
    int         pick;
    logic [7:0] cmd;
    logic [7:0] len;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      return;
    end
    if (pick < 12) begin
      send_byte(HdrByte);
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      return;
    end
    cmd  = (pick < 85) ? 8'($urandom_range(1, 5)) : 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 8) len = 8'($urandom_range(MaxPayload + 1, 255));
    else if (pick < 12) len = 8'(MaxPayload);
    else len = 8'($urandom_range(0, 6));
    send_frame(cmd, 8'($urandom), len, $urandom_range(99) < 15);
  endtask

  task automatic drain_responses();
    rx_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin : tx_receiver
    int hold_left;
    int holds_done;
    hold_left    = 0;
    holds_done   = 0;
    tx_ch.ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && holds_asked != holds_done) begin
        holds_done++;
        hold_left = TxHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        tx_ch.ready <= 1'b0;
      end else begin
        tx_ch.ready <= ($urandom_range(99) >= tx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no beat for %0d cycles", StallLimit);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int target;
    rst_ni        = 1'b0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    rx_idle_pct   = 0;
    tx_idle_pct   = 0;
    holds_asked   = 0;
    bytes_sent    = 0;
    repeat (5) @(negedge clk_i);
    rst_ni      = 1'b1;
    rx_idle_pct = 27;
    tx_idle_pct <= 61;

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_frame(CmdLed0On, 8'h00, 8'd0, 1'b0);
    send_frame(CmdLed1On, 8'hFF, 8'(MaxPayload), 1'b0);
    send_frame(CmdLed0Off, 8'h5A, 8'd1, 1'b0);
    send_frame(CmdLed1Off, 8'hA5, 8'd0, 1'b0);
    send_frame(CmdCheck, 8'h01, 8'd2, 1'b0);
    send_frame(CmdCheck, 8'h02, 8'd0, 1'b0);
    send_frame(UnknownCmdLow, 8'h03, 8'd0, 1'b0);
    send_frame(UnknownCmdHigh, 8'h04, 8'd1, 1'b0);
    send_frame(CmdLed1On, 8'h05, 8'(MaxPayload + 1), 1'b0);
    send_frame(CmdLed0On, 8'h06, 8'hFF, 1'b0);
    send_frame(CmdLed0On, 8'h07, 8'd3, 1'b1);
    send_frame(CmdLed1On, 8'h08, 8'd0, 1'b0);
    send_frame(CmdLed0On, 8'h09, 8'd0, 1'b0);
    drain_responses();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          rx_idle_pct = 27;
          tx_idle_pct <= 61;
        end
        1: begin
          rx_idle_pct = 61;
          tx_idle_pct <= 27;
        end
        default: begin
          rx_idle_pct = 0;
          tx_idle_pct <= 0;
        end
      endcase
      if (ph == 2) begin
        holds_asked <= holds_asked + 1;
        repeat (8) send_frame(CmdLed0On, 8'($urandom), 8'd0, 1'b0);
      end
      target = bytes_sent + PhaseBytes;
      while (bytes_sent < target) send_random_frame();
      drain_responses();
    end

    repeat (TailCycles) @(negedge clk_i);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
